>>> design/ostb_pkg.sv
// package for the one-shot timer bank
// holds transaction structs, command codes, result codes and sizes
// no dependencies
`default_nettype none

package ostb_pkg;

	localparam int TIMER_COUNT_DEF = 8;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;

	localparam logic [1:0] CMD_SET    = 2'd0;
	localparam logic [1:0] CMD_CANCEL = 2'd1;
	localparam logic [1:0] CMD_POLL   = 2'd2;

	localparam logic [1:0] KIND_ACK   = 2'd0;
	localparam logic [1:0] KIND_FIRED = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_ARMED   = 2'd2;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  timer_id;
		logic [31:0] delay_ms;
		logic        force_restart;
		logic [7:0]  action_tag;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] fired_id;
		logic [7:0] fired_tag;
		logic [1:0] status;
		logic       last;
	} out_item_t;

	typedef enum logic [1:0] {
		OP_SET,
		OP_CANCEL,
		OP_POLL,
		OP_BADID
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  id;
		logic [31:0] delay;
		logic        force_restart;
		logic [7:0]  tag;
		logic [31:0] now;
	} job_t;

	typedef struct packed {
		logic [31:0] start;
		logic [31:0] delay;
		logic [7:0]  tag;
	} entry_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_POLL,
		BK_DONE
	} bk_state_t;

endpackage

`default_nettype wire

>>> design/ostb_front.sv
// front stage: accepts input transactions, checks the id and decodes the command
// registers one decoded job for the command queue; uses ostb_pkg
`default_nettype none

module ostb_front #(
	parameter int TIMER_COUNT = ostb_pkg::TIMER_COUNT_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	output logic              full,
	input  ostb_pkg::in_item_t item,
	output logic              job_vld,
	output ostb_pkg::job_t    job,
	input  wire               q_full
);
	import ostb_pkg::*;

	logic   vld_s1;
	job_t   job_s1;
	job_t   job_d;
	logic   accept;
	logic   keep;
	logic   bad_id;
	logic   q_wr;

	assign full   = vld_s1 && q_full;
	assign accept = push && !full;
	assign q_wr   = vld_s1 && !q_full;
	assign bad_id = item.timer_id >= 8'(TIMER_COUNT);

	always_comb begin
		job_d.id            = item.timer_id;
		job_d.delay         = item.delay_ms;
		job_d.force_restart = item.force_restart;
		job_d.tag           = item.action_tag;
		job_d.now           = item.now_ms;
		job_d.op            = OP_POLL;
		keep                = 1'b1;
		unique case (item.cmd)
			CMD_SET: begin
				job_d.op = bad_id ? OP_BADID : OP_SET;
			end
			CMD_CANCEL: begin
				job_d.op = bad_id ? OP_BADID : OP_CANCEL;
			end
			CMD_POLL: begin
				job_d.op = OP_POLL;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= keep;
		end else if (q_wr) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1 <= job_d;
		end
	end

	assign job_vld = q_wr;
	assign job     = job_s1;

endmodule

`default_nettype wire

>>> design/ostb_cmd_fifo.sv
// short command queue between the front and back stages
// uses ostb_pkg for the job struct and queue depth
`default_nettype none

module ostb_cmd_fifo (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            wr_en,
	input  ostb_pkg::job_t wr_data,
	output logic           q_full,
	input  wire            rd_en,
	output ostb_pkg::job_t rd_data,
	output logic           rd_vld
);
	import ostb_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_wr;
	logic              do_rd;

	assign q_full  = cnt_q == (QPTR_W + 1)'(QDEPTH);
	assign rd_vld  = cnt_q != '0;
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && rd_vld;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

>>> design/ostb_back.sv
// back stage: timer entry memory, armed bits, poll sequencer and result register
// executes jobs from the command queue; uses ostb_pkg
`default_nettype none

module ostb_back #(
	parameter int TIMER_COUNT = ostb_pkg::TIMER_COUNT_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                head_vld,
	input  ostb_pkg::job_t     head,
	output logic               head_pop,
	output logic               empty,
	input  wire                pop,
	output ostb_pkg::out_item_t result
);
	import ostb_pkg::*;

	localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_COUNT - 1);

	entry_t           mem [TIMER_COUNT];
	entry_t           rd_q;
	logic [TIMER_COUNT-1:0] armed_q;
	bk_state_t        state_q;
	bk_state_t        state_d;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] idx_d;
	logic             out_vld_q;
	out_item_t        out_q;

	logic             slot_free;
	logic [IDX_W-1:0] hid;
	logic             expired;
	logic             hit;
	logic             out_load;
	out_item_t        out_d;
	logic             mem_we;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             arm_we;
	logic             arm_val;
	logic [IDX_W-1:0] arm_addr;
	logic [31:0]      elapsed;

	assign slot_free = !out_vld_q || pop;
	assign hid       = head.id[IDX_W-1:0];
	assign elapsed   = head.now - rd_q.start;
	assign expired   = elapsed > rd_q.delay;
	assign hit       = armed_q[idx_q] && expired;

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		out_load = 1'b0;
		out_d    = '0;
		head_pop = 1'b0;
		mem_we   = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = idx_q;
		arm_we   = 1'b0;
		arm_val  = 1'b0;
		arm_addr = hid;
		unique case (state_q)
			BK_IDLE: begin
				if (head_vld) begin
					unique case (head.op)
						OP_BADID: begin
							if (slot_free) begin
								out_load = 1'b1;
								out_d    = '{KIND_ACK, head.id, 8'h00, ST_INVALID, 1'b1};
								head_pop = 1'b1;
							end
						end
						OP_SET: begin
							if (slot_free) begin
								out_load = 1'b1;
								head_pop = 1'b1;
								if (armed_q[hid] && !head.force_restart) begin
									out_d = '{KIND_ACK, head.id, 8'h00, ST_ARMED, 1'b1};
								end else begin
									out_d   = '{KIND_ACK, head.id, 8'h00, ST_DONE, 1'b1};
									mem_we  = 1'b1;
									arm_we  = 1'b1;
									arm_val = |head.tag;
								end
							end
						end
						OP_CANCEL: begin
							if (slot_free) begin
								out_load = 1'b1;
								out_d    = '{KIND_ACK, head.id, 8'h00, ST_DONE, 1'b1};
								head_pop = 1'b1;
								arm_we   = 1'b1;
							end
						end
						OP_POLL: begin
							rd_en   = 1'b1;
							rd_addr = '0;
							idx_d   = '0;
							state_d = BK_POLL;
						end
						default: begin
						end
					endcase
				end
			end
			BK_POLL: begin
				if (!hit || slot_free) begin
					if (hit) begin
						out_load = 1'b1;
						out_d    = '{KIND_FIRED, 8'(idx_q), rd_q.tag, ST_DONE, 1'b0};
						arm_we   = 1'b1;
						arm_addr = idx_q;
					end
					if (idx_q == LAST_IDX) begin
						state_d = BK_DONE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = idx_q + 1'b1;
						idx_d   = idx_q + 1'b1;
					end
				end
			end
			BK_DONE: begin
				if (slot_free) begin
					out_load = 1'b1;
					out_d    = '{KIND_DONE, 8'h00, 8'h00, ST_DONE, 1'b1};
					head_pop = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			idx_q     <= '0;
			armed_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (arm_we) begin
				armed_q[arm_addr] <= arm_val;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[hid] <= '{head.now, head.delay, head.tag};
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign empty  = !out_vld_q;
	assign result = out_q;

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !pop |-> !out_load)
		else $error("result register overwritten while waiting");

	// poll walk stays inside the bank
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_POLL |-> idx_q <= LAST_IDX)
		else $error("poll index out of range");

	// an expired report disarms its entry
	a_fire_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && out_d.kind == KIND_FIRED |=> !armed_q[$past(idx_q)])
		else $error("reported timer still armed");

	// the queue head is only released by a final result
	a_pop_last: assert property (@(posedge clk) disable iff (!arst_n)
		head_pop |-> out_load && out_d.last)
		else $error("job released without final result");

endmodule

`default_nettype wire

>>> design/oneshot_timer_bank.sv
// set and cancel: pass the front stage, command queue and result register; one per cycle
// in the back stage while the result register is free; poll: one entry read per cycle from
// the entry memory, held while a fired result waits; sustained rate is set by the poll walk
// asynchronous reset clears every armed bit, the command queue and the result valid flag
// entry times and delays are not reset and only matter for armed entries
`default_nettype none

module oneshot_timer_bank #(
	parameter int TIMER_COUNT = ostb_pkg::TIMER_COUNT_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	output logic                full,
	input  ostb_pkg::in_item_t  item,
	output logic                empty,
	input  wire                 pop,
	output ostb_pkg::out_item_t result
);
	import ostb_pkg::*;

	logic job_vld;
	job_t job;
	logic q_full;
	logic head_pop;
	job_t head;
	logic head_vld;

	ostb_front #(
		.TIMER_COUNT(TIMER_COUNT)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.job_vld(job_vld),
		.job    (job),
		.q_full (q_full)
	);

	ostb_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_vld),
		.wr_data(job),
		.q_full (q_full),
		.rd_en  (head_pop),
		.rd_data(head),
		.rd_vld (head_vld)
	);

	ostb_back #(
		.TIMER_COUNT(TIMER_COUNT)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head_vld(head_vld),
		.head    (head),
		.head_pop(head_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps
// testbench for oneshot_timer_bank: directed and random set, cancel and poll traffic,
// every result checked against an in-bench prediction of the timer bank
// depends on ostb_pkg and the oneshot_timer_bank rtl

module tb;
	import ostb_pkg::*;

	localparam int NTIMERS = TIMER_COUNT_DEF;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 30;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      push;
	logic      full;
	in_item_t  item;
	logic      empty;
	logic      pop;
	out_item_t result;

	logic [31:0] timer_start [NTIMERS];
	logic [31:0] timer_delay [NTIMERS];
	logic [7:0]  timer_tag [NTIMERS];
	out_item_t   due_results [$];

	int          err_count = 0;
	int          cycle_count = 0;
	int          hold_cycles = 0;
	bit          no_gaps = 1'b0;
	logic [31:0] clock_ms = '0;

	oneshot_timer_bank DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic out_item_t make_result(input logic [1:0] kind, input logic [7:0] id,
			input logic [7:0] tag, input logic [1:0] status, input logic last);
		out_item_t r;
		r.kind = kind;
		r.fired_id = id;
		r.fired_tag = tag;
		r.status = status;
		r.last = last;
		return r;
	endfunction

	// updates the timer state and queues the results one command causes
	function automatic void run_command(input in_item_t c);
		logic [31:0] elapsed;
		int i;
		case (c.cmd)
			CMD_SET: begin
				if (c.timer_id >= NTIMERS) begin
					due_results.push_back(make_result(KIND_ACK, c.timer_id, 8'd0, ST_INVALID, 1'b1));
				end else if (timer_tag[c.timer_id] != 8'd0 && !c.force_restart) begin
					due_results.push_back(make_result(KIND_ACK, c.timer_id, 8'd0, ST_ARMED, 1'b1));
				end else begin
					timer_start[c.timer_id] = c.now_ms;
					timer_delay[c.timer_id] = c.delay_ms;
					timer_tag[c.timer_id] = c.action_tag;
					due_results.push_back(make_result(KIND_ACK, c.timer_id, 8'd0, ST_DONE, 1'b1));
				end
			end
			CMD_CANCEL: begin
				if (c.timer_id >= NTIMERS) begin
					due_results.push_back(make_result(KIND_ACK, c.timer_id, 8'd0, ST_INVALID, 1'b1));
				end else begin
					timer_tag[c.timer_id] = 8'd0;
					due_results.push_back(make_result(KIND_ACK, c.timer_id, 8'd0, ST_DONE, 1'b1));
				end
			end
			CMD_POLL: begin
				for (i = 0; i < NTIMERS; i++) begin
					elapsed = c.now_ms - timer_start[i];
					if (timer_tag[i] != 8'd0 && elapsed > timer_delay[i]) begin
						due_results.push_back(make_result(KIND_FIRED, 8'(i), timer_tag[i], ST_DONE,
							1'b0));
						timer_tag[i] = 8'd0;
					end
				end
				due_results.push_back(make_result(KIND_DONE, 8'd0, 8'd0, ST_DONE, 1'b1));
			end
			default: begin
			end
		endcase
	endfunction

	function automatic in_item_t mk(input logic [1:0] cmd, input logic [7:0] id,
			input logic [31:0] delay, input logic frc, input logic [7:0] tag,
			input logic [31:0] now);
		in_item_t it;
		it.cmd = cmd;
		it.timer_id = id;
		it.delay_ms = delay;
		it.force_restart = frc;
		it.action_tag = tag;
		it.now_ms = now;
		return it;
	endfunction

	// mostly valid timers on a slowly advancing clock, some noise
	function automatic in_item_t random_command();
		in_item_t it;
		int pick;
		it.timer_id = 8'($urandom_range(0, NTIMERS - 1));
		it.delay_ms = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 60);
		it.force_restart = 1'($urandom_range(0, 1));
		it.action_tag = ($urandom_range(0, 15) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
		if ($urandom_range(0, 9) == 0) begin
			clock_ms = $urandom;
		end else begin
			clock_ms = clock_ms + $urandom_range(0, 25);
		end
		it.now_ms = clock_ms;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			it.cmd = CMD_SET;
		end else if (pick < 55) begin
			it.cmd = CMD_SET;
			it.timer_id = 8'($urandom_range(0, 255));
		end else if (pick < 65) begin
			it.cmd = CMD_CANCEL;
			if ($urandom_range(0, 3) == 0) begin
				it.timer_id = 8'($urandom_range(0, 255));
			end
		end else if (pick < 95) begin
			it.cmd = CMD_POLL;
		end else begin
			it.cmd = CMD_UNUSED;
		end
		return it;
	endfunction

	task automatic report(input string msg);
		$display("ERROR cycle %0d: %s", cycle_count, msg);
		err_count++;
	endtask

	task automatic send_item(input in_item_t it);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		run_command(it);
	endtask

	// result side: random stalls, optional long hold-off, field-by-field check
	initial begin
		int stall;
		out_item_t got;
		out_item_t want;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_cycles > 0) begin
				pop <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			stall = no_gaps ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			got = result;
			if (due_results.size() == 0) begin
				report($sformatf("unexpected transaction kind %0d id %0d", got.kind,
					got.fired_id));
			end else begin
				want = due_results.pop_front();
				if (got.kind !== want.kind)
					report($sformatf("kind exp %0d got %0d", want.kind, got.kind));
				if (got.fired_id !== want.fired_id)
					report($sformatf("fired_id exp %0d got %0d", want.fired_id, got.fired_id));
				if (got.fired_tag !== want.fired_tag)
					report($sformatf("fired_tag exp %0h got %0h", want.fired_tag,
						got.fired_tag));
				if (got.status !== want.status)
					report($sformatf("status exp %0d got %0d", want.status, got.status));
				if (got.last !== want.last)
					report($sformatf("last exp %0d got %0d", want.last, got.last));
			end
		end
	end

	task automatic test_set_cancel();
		send_item(mk(CMD_SET, 8'd0, 32'd5, 1'b0, 8'hFF, 32'hFFFF_FFFE));
		send_item(mk(CMD_SET, 8'd0, 32'd0, 1'b0, 8'd1, 32'd0));
		send_item(mk(CMD_SET, 8'd7, 32'hFFFF_FFFF, 1'b1, 8'h80, 32'hFFFF_FFFF));
		send_item(mk(CMD_SET, 8'd7, 32'd0, 1'b1, 8'h7F, 32'd0));
		send_item(mk(CMD_SET, 8'd8, 32'd1, 1'b1, 8'd3, 32'd0));
		send_item(mk(CMD_SET, 8'd255, 32'hFFFF_FFFF, 1'b1, 8'hFF, 32'hFFFF_FFFF));
		send_item(mk(CMD_CANCEL, 8'd255, 32'd0, 1'b0, 8'd0, 32'd0));
		send_item(mk(CMD_CANCEL, 8'd7, 32'd0, 1'b0, 8'd0, 32'd0));
		send_item(mk(CMD_CANCEL, 8'd7, 32'd0, 1'b0, 8'd0, 32'd0));
		send_item(mk(CMD_SET, 8'd3, 32'd0, 1'b0, 8'd0, 32'd0));
		send_item(mk(CMD_SET, 8'd3, 32'd9, 1'b0, 8'd0, 32'd1));
		send_item(mk(CMD_UNUSED, 8'd1, 32'hFFFF_FFFF, 1'b1, 8'hFF, 32'hFFFF_FFFF));
	endtask

	task automatic test_poll();
		int i;
		// elapsed equal to delay across the wrap does not fire, one more does
		send_item(mk(CMD_POLL, 8'd0, 32'd0, 1'b0, 8'd0, 32'd3));
		send_item(mk(CMD_POLL, 8'd0, 32'd0, 1'b0, 8'd0, 32'd4));
		send_item(mk(CMD_SET, 8'd1, 32'hFFFF_FFFF, 1'b1, 8'h55, 32'd0));
		send_item(mk(CMD_POLL, 8'd0, 32'd0, 1'b0, 8'd0, 32'hFFFF_FFFF));
		for (i = 0; i < NTIMERS; i++)
			send_item(mk(CMD_SET, 8'(i), 32'd0, 1'b1, 8'(8'hA0 + i), 32'd100));
		send_item(mk(CMD_POLL, 8'd0, 32'd0, 1'b0, 8'd0, 32'd101));
		send_item(mk(CMD_POLL, 8'd0, 32'd0, 1'b0, 8'd0, 32'd101));
	endtask

	task automatic test_back_to_back();
		no_gaps = 1'b1;
		repeat (20) send_item(random_command());
		no_gaps = 1'b0;
	endtask

	task automatic test_backpressure();
		hold_cycles = 150;
		repeat (20) send_item(random_command());
	endtask

	task automatic test_random();
		repeat (210) send_item(random_command());
	endtask

	initial begin
		int i;
		for (i = 0; i < NTIMERS; i++) begin
			timer_start[i] = '0;
			timer_delay[i] = '0;
			timer_tag[i] = '0;
		end
		arst_n <= 1'b0;
		push <= 1'b0;
		item <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_set_cancel();
		test_poll();
		test_back_to_back();
		test_backpressure();
		test_random();
		push <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

>>> files.f
design/ostb_pkg.sv
design/ostb_front.sv
design/ostb_cmd_fifo.sv
design/ostb_back.sv
design/oneshot_timer_bank.sv
sim/tb.sv
